### hw/rtl/skyp_pkg.sv
// Shared types and constants of the skyline rectangle packer.
// Used by skyp_cell and skyline_rectangle_packer_core; depends on nothing.
package skyp_pkg;

   localparam logic       CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic       CSR_ATLAS_HEIGHT = 1'b1;
   localparam logic [12:0] DIM_RESET       = 13'd512;
   localparam logic [12:0] DIM_MIN         = 13'd3;
   localparam logic [12:0] DIM_MAX         = 13'd4096;
   localparam logic [12:0] SEG_X_INIT      = 13'd1;
   localparam logic [12:0] SEG_LEVEL_INIT  = 13'd1;
   localparam logic [12:0] RESET_WIDTH     = DIM_RESET - 13'd2;

   typedef enum logic [3:0] {
      OP_HOLD, OP_CLEAR, OP_LOAD, OP_SEARCH, OP_RANK, OP_SELECT,
      OP_INSERT, OP_TRIM, OP_MERGE, OP_COMPACT
   } cell_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_LOAD, ST_SEARCH, ST_RANK, ST_SELECT,
      ST_DECIDE, ST_INSERT, ST_TRIM, ST_COMPACT, ST_MERGE, ST_DONE
   } skyp_state_type;

   typedef struct packed {
      logic        valid;
      logic [12:0] x;
      logic [12:0] level;
      logic [12:0] width;
   } seg_type;

   typedef struct packed {
      logic        valid;
      logic [12:0] level;
      logic [12:0] width;
   } probe_type;

   typedef struct packed {
      logic        fit;
      logic [13:0] top;
      logic [12:0] width;
      logic [12:0] x;
      logic [12:0] level;
   } cand_type;

   typedef struct packed {
      cell_op_type op;
      logic [11:0] w;
      logic [11:0] h;
      logic [11:0] wlim;
      logic [11:0] hlim;
      logic [12:0] init_width;
      logic [12:0] new_x;
      logic [12:0] new_level;
      logic [13:0] end_x;
   } cell_ctl_type;

   function automatic logic [12:0] clamp_dim(input logic [12:0] v);
      logic [12:0] r;
      r = v;
      if (v < DIM_MIN) r = DIM_MIN;
      else if (v > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

endpackage

### hw/rtl/skyline_rectangle_packer_core.sv
// Skyline bottom-left packer for a bordered texture atlas: top level with the
// sequencer and the row of skyp_cell segments. Depends on skyp_pkg and skyp_cell.
//
// One request is worked at a time. A clear goes through the clear state to its
// response. An add runs the segment row through a walk, in which every cell
// tests itself as a start while segment data moves down the row, then a
// ranking shift; a rejected add or one of zero width answers after these, a
// placement after an insert, a trim and three compaction sweeps that close
// the gaps left by trimmed and merged segments. A new request is taken while the
// last response still waits. The atlas size is read at clear and at every add.
module skyline_rectangle_packer_core #(
   parameter int MAX_SEGMENTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rect_width [11:0], rect_height [23:12]
   input  logic        req_tuser,   // func [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pos_x [11:0], pos_y [23:12], used_area [48:24]
   output logic        rsp_tuser,   // placed [0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);
   import skyp_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(MAX_SEGMENTS - 1);

   skyp_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [12:0]    aw_ff, ah_ff;
   logic [11:0]    w_ff, w_in, h_ff, h_in;
   logic           found_ff, found_in, placed_ff, placed_in;
   logic [13:0]    best_top_ff, best_top_in;
   logic [12:0]    best_w_ff, best_w_in, bx_ff, bx_in, by_ff, by_in;
   logic [IW-1:0]  best_idx_ff, best_idx_in;
   logic [23:0]    prod_ff, prod_in;
   logic [24:0]    area_ff, area_in;
   logic [25:0]    area_sum;
   logic [1:0]     mrg_ff, mrg_in;
   logic           rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic [55:0]    rsp_data_ff, rsp_data_in;
   logic [12:0]    aw_c, ah_c;
   cell_ctl_type   ctl;
   cell_op_type    op_c;
   cand_type       head_cand;

   seg_type   seg_vec   [MAX_SEGMENTS];
   probe_type probe_vec [MAX_SEGMENTS];
   cand_type  cand_vec  [MAX_SEGMENTS];
   logic      absorb_vec[MAX_SEGMENTS];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign aw_c           = clamp_dim(aw_ff);
   assign ah_c           = clamp_dim(ah_ff);
   assign ctl.op         = op_c;
   assign ctl.w          = w_ff;
   assign ctl.h          = h_ff;
   assign ctl.wlim       = 12'(aw_c - 13'd1);
   assign ctl.hlim       = 12'(ah_c - 13'd1);
   assign ctl.init_width = aw_c - 13'd2;
   assign ctl.new_x      = bx_ff;
   assign ctl.new_level  = by_ff + {1'b0, h_ff};
   assign ctl.end_x      = {1'b0, bx_ff} + {2'b0, w_ff};
   assign head_cand      = cand_vec[0];
   assign area_sum       = {1'b0, area_ff} + {2'b0, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff <= DIM_RESET;
         ah_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ATLAS_WIDTH) aw_ff <= csr_data;
         if (csr_index == CSR_ATLAS_HEIGHT) ah_ff <= csr_data;
      end
   end

   genvar k;
   generate
      for (k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
         seg_type   below_s, above_s;
         probe_type above_p;
         cand_type  above_c;
         logic      below_a;
         if (k == 0) begin : g_first
            assign below_s = '{valid: 1'b1, x: '0, level: '0, width: '0};
            assign below_a = 1'b0;
         end else begin : g_mid_lo
            assign below_s = seg_vec[k-1];
            assign below_a = absorb_vec[k-1];
         end
         if (k == MAX_SEGMENTS - 1) begin : g_last
            assign above_s = '0;
            assign above_p = '0;
            assign above_c = '0;
         end else begin : g_mid_hi
            assign above_s = seg_vec[k+1];
            assign above_p = probe_vec[k+1];
            assign above_c = cand_vec[k+1];
         end
         skyp_cell #(.IDX(k), .IW(IW)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .best_idx    (best_idx_ff),
            .below_seg   (below_s),
            .above_seg   (above_s),
            .below_absorb(below_a),
            .absorb      (absorb_vec[k]),
            .seg_out     (seg_vec[k]),
            .probe_above (above_p),
            .probe_out   (probe_vec[k]),
            .cand_above  (above_c),
            .cand_out    (cand_vec[k])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      found_in     = found_ff;
      placed_in    = placed_ff;
      best_top_in  = best_top_ff;
      best_w_in    = best_w_ff;
      best_idx_in  = best_idx_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      prod_in      = prod_ff;
      area_in      = area_ff;
      mrg_in       = mrg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      op_c         = OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               w_in      = req_tdata[11:0];
               h_in      = req_tdata[23:12];
               prod_in   = req_tdata[11:0] * req_tdata[23:12];
               found_in  = 1'b0;
               placed_in = 1'b0;
               bx_in     = '0;
               by_in     = '0;
               state_in  = req_tuser ? ST_CLEAR : ST_LOAD;
            end
         end
         ST_CLEAR: begin
            op_c     = OP_CLEAR;
            area_in  = '0;
            state_in = ST_DONE;
         end
         ST_LOAD: begin
            op_c     = OP_LOAD;
            cnt_in   = '0;
            mrg_in   = '0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            op_c   = OP_SEARCH;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) state_in = ST_RANK;
         end
         ST_RANK: begin
            op_c     = OP_RANK;
            cnt_in   = '0;
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            // Candidates in segment order; ties go to the narrower, then earlier.
            op_c = OP_SELECT;
            if (head_cand.fit && (!found_ff || head_cand.top < best_top_ff ||
                (head_cand.top == best_top_ff && head_cand.width < best_w_ff))) begin
               found_in    = 1'b1;
               best_top_in = head_cand.top;
               best_w_in   = head_cand.width;
               best_idx_in = cnt_ff[IW-1:0];
               bx_in       = head_cand.x;
               by_in       = head_cand.level;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (found_ff && (w_ff == '0 || !seg_vec[MAX_SEGMENTS-1].valid)) begin
               placed_in = 1'b1;
               if (w_ff != '0) state_in = ST_INSERT;
            end else begin
               bx_in = '0;
               by_in = '0;
            end
         end
         ST_INSERT: begin
            op_c     = OP_INSERT;
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            op_c     = OP_TRIM;
            cnt_in   = '0;
            state_in = ST_COMPACT;
         end
         ST_COMPACT: begin
            op_c   = OP_COMPACT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               if (mrg_ff != 2'd2) begin
                  mrg_in   = mrg_ff + 1'b1;
                  state_in = ST_MERGE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MERGE: begin
            op_c     = OP_MERGE;
            cnt_in   = '0;
            state_in = ST_COMPACT;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (placed_ff) area_in = area_sum[25] ? '1 : area_sum[24:0];
               rsp_valid_in = 1'b1;
               rsp_user_in  = placed_ff;
               rsp_data_in  = {7'b0, area_in, by_ff[11:0], bx_ff[11:0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mrg_ff       <= '0;
         found_ff     <= 1'b0;
         placed_ff    <= 1'b0;
         area_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mrg_ff       <= mrg_in;
         found_ff     <= found_in;
         placed_ff    <= placed_in;
         area_ff      <= area_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      best_top_ff <= best_top_in;
      best_w_ff   <= best_w_in;
      best_idx_ff <= best_idx_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // The first segment is never trimmed, absorbed or moved out.
   a_first_seg_live: assert property (@(posedge clock) disable iff (reset)
      seg_vec[0].valid)
      else $error("first skyline segment lost");

   // Used area only drops on a clear.
   a_area_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> area_ff >= $past(area_ff))
      else $error("used area decreased without clear");

   // Insertion always happens at an occupied segment and only with room left.
   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> seg_vec[best_idx_ff].valid &&
                                !seg_vec[MAX_SEGMENTS-1].valid && placed_ff)
      else $error("insert at empty segment or into full table");

endmodule

### hw/rtl/skyp_cell.sv
// One cell of the skyline chain: holds a segment, walks a candidate start and
// passes probe, candidate and segment data to its neighbors. Depends on skyp_pkg.
module skyp_cell #(
   parameter int IDX = 0,
   parameter int IW  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  skyp_pkg::cell_ctl_type ctl,
   input  logic [IW-1:0]          best_idx,
   input  skyp_pkg::seg_type      below_seg,
   input  skyp_pkg::seg_type      above_seg,
   input  logic                   below_absorb,
   output logic                   absorb,
   output skyp_pkg::seg_type      seg_out,
   input  skyp_pkg::probe_type    probe_above,
   output skyp_pkg::probe_type    probe_out,
   input  skyp_pkg::cand_type     cand_above,
   output skyp_pkg::cand_type     cand_out
);
   import skyp_pkg::*;

   localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
   localparam bit            IS_FIRST = (IDX == 0);

   seg_type     seg_ff, seg_in;
   probe_type   probe_ff, probe_in;
   cand_type    cand_ff, cand_in;
   logic [12:0] lvl_ff, lvl_in;
   logic [11:0] left_ff, left_in;
   logic        fail_ff, fail_in;
   logic        head;
   logic [13:0] xw, topv, xe;

   assign seg_out   = seg_ff;
   assign probe_out = probe_ff;
   assign cand_out  = cand_ff;

   // A cell heads a run of equal levels when its lower neighbor differs.
   assign head   = seg_ff.valid &
                   !(!IS_FIRST && below_seg.valid && below_seg.level == seg_ff.level);
   assign absorb = head & above_seg.valid & (above_seg.level == seg_ff.level);

   assign xw   = {1'b0, seg_ff.x} + {2'b0, ctl.w};
   assign topv = {1'b0, lvl_ff} + {2'b0, ctl.h};
   assign xe   = {1'b0, seg_ff.x} + {1'b0, seg_ff.width};

   always_comb begin
      seg_in   = seg_ff;
      probe_in = probe_ff;
      cand_in  = cand_ff;
      lvl_in   = lvl_ff;
      left_in  = left_ff;
      fail_in  = fail_ff;
      case (ctl.op)
         OP_CLEAR: begin
            seg_in.valid = IS_FIRST;
            seg_in.x     = SEG_X_INIT;
            seg_in.level = SEG_LEVEL_INIT;
            seg_in.width = ctl.init_width;
         end
         OP_LOAD: begin
            probe_in = '{valid: seg_ff.valid, level: seg_ff.level, width: seg_ff.width};
            lvl_in   = seg_ff.level;
            left_in  = ctl.w;
            fail_in  = !seg_ff.valid || (xw > {2'b0, ctl.wlim});
         end
         OP_SEARCH: begin
            if (!fail_ff && left_ff != '0) begin
               if (!probe_ff.valid) begin
                  fail_in = 1'b1;
               end else begin
                  if (probe_ff.level > lvl_ff) lvl_in = probe_ff.level;
                  if ({1'b0, left_ff} <= probe_ff.width) left_in = '0;
                  else left_in = left_ff - probe_ff.width[11:0];
               end
            end
            probe_in = probe_above;
         end
         OP_RANK: begin
            cand_in.fit   = !fail_ff && (left_ff == '0) && (topv <= {2'b0, ctl.hlim});
            cand_in.top   = topv;
            cand_in.width = seg_ff.width;
            cand_in.x     = seg_ff.x;
            cand_in.level = lvl_ff;
         end
         OP_SELECT: begin
            cand_in = cand_above;
         end
         OP_INSERT: begin
            if (MY_IDX == best_idx) begin
               seg_in.valid = 1'b1;
               seg_in.x     = ctl.new_x;
               seg_in.level = ctl.new_level;
               seg_in.width = {1'b0, ctl.w};
            end else if (MY_IDX > best_idx) begin
               seg_in = below_seg;
            end
         end
         OP_TRIM: begin
            if (seg_ff.valid && MY_IDX > best_idx) begin
               if (xe <= ctl.end_x) begin
                  seg_in.valid = 1'b0;
               end else if ({1'b0, seg_ff.x} < ctl.end_x) begin
                  seg_in.x     = ctl.end_x[12:0];
                  seg_in.width = 13'(xe - ctl.end_x);
               end
            end
         end
         OP_MERGE: begin
            if (absorb) seg_in.width = seg_ff.width + above_seg.width;
            if (below_absorb) seg_in.valid = 1'b0;
         end
         OP_COMPACT: begin
            // Holes bubble upward one cell per cycle, live segments keep order.
            if (!seg_ff.valid && above_seg.valid) seg_in = above_seg;
            else if (seg_ff.valid && !below_seg.valid) seg_in.valid = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff.valid <= IS_FIRST;
         seg_ff.x     <= SEG_X_INIT;
         seg_ff.level <= SEG_LEVEL_INIT;
         seg_ff.width <= RESET_WIDTH;
      end else begin
         seg_ff <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      cand_ff  <= cand_in;
      lvl_ff   <= lvl_in;
      left_ff  <= left_in;
      fail_ff  <= fail_in;
   end

endmodule

### test/skyline_rectangle_packer_core_tb.sv
// Self-checking testbench for skyline_rectangle_packer_core: drives add and clear
// requests and atlas size writes, and checks every response against a skyline predictor.
// Depends on skyp_pkg and the packer RTL only.
`timescale 1ns / 1ps

module skyline_rectangle_packer_core_tb;
   import skyp_pkg::*;

   localparam int SEGS = 256;
   localparam int SEG_LATENCY = 5 * SEGS + 40;
   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;
   localparam longint CYCLE_LIMIT = 12000000;
   localparam int HOLD_LEN = 6000;

   typedef struct {
      bit       placed;
      bit [11:0] x;
      bit [11:0] y;
      bit [24:0] area;
   } placement_type;

   class skyline_board;
      int seg_x[SEGS], seg_lvl[SEGS], seg_w[SEGS];
      int seg_cnt, area;
      int atlas_w, atlas_h;
      int errors, n_placed, n_refused, n_clear;
      placement_type pending[$];

      function int clampd(int v);
         if (v < 3) return 3;
         if (v > 4096) return 4096;
         return v;
      endfunction

      function void restart();
         seg_x[0] = 1;
         seg_lvl[0] = 1;
         seg_w[0] = clampd(atlas_w) - 2;
         seg_cnt = 1;
         area = 0;
      endfunction

      function void drop_seg(int k);
         for (int m = k; m + 1 < seg_cnt; m++) begin
            seg_x[m] = seg_x[m + 1];
            seg_lvl[m] = seg_lvl[m + 1];
            seg_w[m] = seg_w[m + 1];
         end
         seg_cnt--;
      endfunction

      // Resting level of a w x h rectangle started at segment i, or -1 if it does not fit.
      function int rest_level(int i, int w, int h);
         int lvl, left, j;
         if (seg_x[i] + w > clampd(atlas_w) - 1) return -1;
         lvl = seg_lvl[i];
         left = w;
         j = i;
         while (left > 0) begin
            if (j >= seg_cnt) return -1;
            if (seg_lvl[j] > lvl) lvl = seg_lvl[j];
            left -= seg_w[j];
            j++;
         end
         if (lvl + h > clampd(atlas_h) - 1) return -1;
         return lvl;
      endfunction

      function void note_request(bit func, int w, int h);
         placement_type p;
         int best_top, best_w, best, bx, by, lvl, j, i, fin, cut, a;
         bit found;
         p = '{0, 0, 0, 0};
         if (func == FUNC_CLEAR) begin
            restart();
            n_clear++;
            pending.push_back(p);
            return;
         end
         best_top = 32'h7fffffff;
         best_w = 32'h7fffffff;
         best = 0; bx = 0; by = 0;
         found = 0;
         for (i = 0; i < seg_cnt; i++) begin
            lvl = rest_level(i, w, h);
            if (lvl < 0) continue;
            if (lvl + h < best_top || (lvl + h == best_top && seg_w[i] < best_w)) begin
               best_top = lvl + h;
               best_w = seg_w[i];
               best = i;
               bx = seg_x[i];
               by = lvl;
               found = 1;
            end
         end
         if (!found || (w > 0 && seg_cnt >= SEGS)) begin
            p.area = area[24:0];
            n_refused++;
            pending.push_back(p);
            return;
         end
         if (w > 0) begin
            for (int k = seg_cnt; k > best; k--) begin
               seg_x[k] = seg_x[k - 1];
               seg_lvl[k] = seg_lvl[k - 1];
               seg_w[k] = seg_w[k - 1];
            end
            seg_x[best] = bx;
            seg_lvl[best] = by + h;
            seg_w[best] = w;
            seg_cnt++;
            // Trim the segments now hidden under the new top.
            j = best + 1;
            while (j < seg_cnt) begin
               fin = seg_x[j - 1] + seg_w[j - 1];
               if (seg_x[j] >= fin) break;
               cut = fin - seg_x[j];
               seg_x[j] += cut;
               seg_w[j] -= cut;
               if (seg_w[j] <= 0) drop_seg(j);
               else break;
            end
            i = 0;
            while (i + 1 < seg_cnt) begin
               if (seg_lvl[i] == seg_lvl[i + 1]) begin
                  seg_w[i] += seg_w[i + 1];
                  drop_seg(i + 1);
               end else begin
                  i++;
               end
            end
         end
         a = area + w * h;
         area = (a > 32'h1ffffff) ? 32'h1ffffff : a;
         p.placed = 1;
         p.x = bx[11:0];
         p.y = by[11:0];
         p.area = area[24:0];
         n_placed++;
         pending.push_back(p);
      endfunction

      task report(string what, longint got, longint want);
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_response(bit placed, bit [11:0] x, bit [11:0] y, bit [24:0] a);
         placement_type p;
         if (pending.size() == 0) begin
            report("response with no request outstanding", placed, 0);
            return;
         end
         p = pending.pop_front();
         if (placed != p.placed) report("placed", placed, p.placed);
         if (x != p.x) report("pos_x", x, p.x);
         if (y != p.y) report("pos_y", y, p.y);
         if (a != p.area) report("used_area", a, p.area);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [12:0] csr_data;

   skyline_board board;
   int send_idle_pct, recv_idle_pct;
   int hold_cycles = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int sent;
   longint cycles = 0;

   skyline_rectangle_packer_core #(.MAX_SEGMENTS(SEGS)) uut (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off once it is armed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_done <= 1'b1;
         hold_cycles <= HOLD_LEN - 1;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tuser, rsp_tdata[11:0], rsp_tdata[23:12], rsp_tdata[48:24]);
   end

   task send_req(logic func, int w, int h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {h[11:0], w[11:0]};
      do @(posedge clock); while (!req_tready);
      board.note_request(func, w[11:0], h[11:0]);
      sent++;
      @(negedge clock);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (SEG_LATENCY) @(negedge clock);
   endtask

   task write_dim(logic idx, int v);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v[12:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ATLAS_WIDTH) board.atlas_w = v[12:0];
      else board.atlas_h = v[12:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Width-1 columns of alternating height build a saw-tooth skyline that fills the table.
   task staircase(int n);
      for (int k = 0; k < n; k++) send_req(FUNC_ADD, 1, 1 + (k % 2));
      send_req(FUNC_ADD, 0, 3);
      send_req(FUNC_CLEAR, 0, 0);
   endtask

   task random_phase(int n_items, bit extremes);
      int lim, aw, ah, w, h, r, stop;
      stop = sent + n_items;
      while (sent < stop) begin
         r = $urandom_range(99);
         if (r < 10) begin
            if (extremes && $urandom_range(1)) aw = $urandom_range(1) ? 4096 : 8191;
            else aw = $urandom_range(3, 1024);
            ah = $urandom_range(1) ? $urandom_range(0, 8191) : $urandom_range(3, 1024);
            write_dim(CSR_ATLAS_WIDTH, aw);
            write_dim(CSR_ATLAS_HEIGHT, ah);
            send_req(FUNC_CLEAR, $urandom_range(4095), $urandom_range(4095));
         end else if (r < 85) begin
            // A fill run with sizes scaled to the atlas, ending in a clear.
            lim = board.clampd(board.atlas_w) / 6;
            if (lim < 1) lim = 1;
            repeat ($urandom_range(10, 30)) begin
               w = $urandom_range(1, lim);
               h = $urandom_range(1, lim);
               if ($urandom_range(19) == 0) w = 0;
               send_req(FUNC_ADD, w, h);
            end
            send_req(FUNC_CLEAR, $urandom_range(4095), $urandom_range(4095));
         end else begin
            repeat ($urandom_range(1, 4))
               send_req($urandom_range(1), $urandom_range(4095), $urandom_range(4095));
         end
      end
   endtask

   initial begin
      board = new();
      board.atlas_w = 512;
      board.atlas_h = 512;
      board.restart();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_ATLAS_WIDTH;
      csr_data = '0;
      sent = 0;
      send_idle_pct = 14;
      recv_idle_pct = 67;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: exact fit, no fit, zero sizes, extremes, clear with junk fields.
      send_req(FUNC_ADD, 0, 0);
      send_req(FUNC_ADD, 510, 510);
      send_req(FUNC_ADD, 1, 1);
      send_req(FUNC_CLEAR, 4095, 4095);
      send_req(FUNC_ADD, 511, 1);
      send_req(FUNC_ADD, 1, 511);
      send_req(FUNC_ADD, 0, 5);
      send_req(FUNC_ADD, 4095, 4095);
      send_req(FUNC_ADD, 100, 40);
      send_req(FUNC_ADD, 50, 40);
      send_req(FUNC_ADD, 50, 20);
      send_req(FUNC_ADD, 200, 60);
      send_req(FUNC_ADD, 30, 30);
      // Raising the width without a clear leaves a skyline that is too short.
      write_dim(CSR_ATLAS_WIDTH, 4096);
      send_req(FUNC_ADD, 600, 10);
      send_req(FUNC_ADD, 20, 10);
      write_dim(CSR_ATLAS_WIDTH, 2);
      write_dim(CSR_ATLAS_HEIGHT, 8191);
      send_req(FUNC_CLEAR, 0, 0);
      send_req(FUNC_ADD, 1, 4094);
      send_req(FUNC_ADD, 1, 1);
      write_dim(CSR_ATLAS_WIDTH, 4096);
      write_dim(CSR_ATLAS_HEIGHT, 4096);
      send_req(FUNC_CLEAR, 0, 0);
      send_req(FUNC_ADD, 4094, 4094);
      send_req(FUNC_ADD, 0, 0);

      random_phase(370, 1'b0);
      drain();
      send_idle_pct = 67;
      recv_idle_pct = 14;
      random_phase(370, 1'b1);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed = 1'b1;
      repeat (6) send_req(FUNC_ADD, $urandom_range(1, 40), $urandom_range(1, 40));
      write_dim(CSR_ATLAS_WIDTH, 4096);
      write_dim(CSR_ATLAS_HEIGHT, 4096);
      send_req(FUNC_CLEAR, 0, 0);
      staircase(262);
      random_phase(130, 1'b1);
      write_dim(CSR_ATLAS_WIDTH, 512);
      write_dim(CSR_ATLAS_HEIGHT, 3);
      send_req(FUNC_CLEAR, 0, 0);
      send_req(FUNC_ADD, 1, 1);
      send_req(FUNC_ADD, 1, 2);
      drain();

      $display("covered %0d requests: %0d placements, %0d refusals, %0d clears",
               sent, board.n_placed, board.n_refused, board.n_clear);
      $display("atlas sizes from clamped minimum to 4096, including a full segment table");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
